// ----- sv/assert_macros.svh -----
// assertion macros used by the top level of the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/rpc_pkg.sv -----
// shared types and constants of the red pixel centroid core
package rpc_pkg;

    localparam int CHAN_W   = 8;
    localparam int COORD_W  = 10;
    localparam int SUM_W    = 30;
    localparam int COUNT_W  = 21;
    localparam int FRAC_W   = 4;
    localparam int Q4_W     = 14;
    localparam int CFG_W    = 21;
    localparam int CFG_IDX_W = 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RED_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PIXELS = 1'd1;

    localparam logic [CHAN_W-1:0]  RED_OFFSET_RST = 8'd10;
    localparam logic [COUNT_W-1:0] MIN_PIXELS_RST = 21'd5;

    // totals of one frame, handed from front to back
    typedef struct packed {
        logic               found;
        logic [SUM_W-1:0]   col_sum;
        logic [SUM_W-1:0]   row_sum;
        logic [COUNT_W-1:0] count;
    } frame_sum_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- sv/red_pixel_centroid_core.sv -----
// top level of the red pixel centroid core
// Takes one pixel beat per cycle with no gaps of its own: the red test and the
// col/row/count accumulation finish in the cycle the beat is accepted. The beat
// that carries frame_end drops the frame totals into a two-entry queue; the back
// end then divides both sums by the count with a radix-2 restoring divider, one
// quotient bit per cycle for col and row in parallel; a frame with nothing found
// skips the divider, and res_stall holds the previous result. pix_stall rises
// only while both queue entries are taken, which needs frames to end faster than
// the back end takes them, or a long stall on the result side. The pixel count
// stops at the smaller of MAX_WIDTH*MAX_HEIGHT and 2^20; red pixels past that
// are ignored.
`include "assert_macros.svh"

module red_pixel_centroid_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [rpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  logic [rpc_pkg::CHAN_W-1:0]     red,
    input  logic [rpc_pkg::CHAN_W-1:0]     green,
    input  logic [rpc_pkg::CHAN_W-1:0]     blue,
    input  logic [rpc_pkg::COORD_W-1:0]    col,
    input  logic [rpc_pkg::COORD_W-1:0]    row,
    input  logic                           frame_end,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic                           found,
    output logic [rpc_pkg::Q4_W-1:0]       mean_col_q4,
    output logic [rpc_pkg::Q4_W-1:0]       mean_row_q4
);
    import rpc_pkg::*;

    localparam longint AREA      = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam longint COUNT_LIM = 64'd1048576;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (AREA < COUNT_LIM) ? COUNT_W'(AREA) : COUNT_W'(COUNT_LIM);

    logic [CHAN_W-1:0]  red_offset_reg;
    logic [COUNT_W-1:0] min_pixels_reg;
    q_status_t          q_stat;
    frame_sum_t         push_data, pop_data;
    logic               q_push, q_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_offset_reg <= RED_OFFSET_RST;
            min_pixels_reg <= MIN_PIXELS_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_RED_OFFSET: red_offset_reg <= cfg_data[CHAN_W-1:0];
                REG_MIN_PIXELS: min_pixels_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel classification and accumulation
    rpc_front #(
        .COUNT_CAP (COUNT_CAP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .col        (col),
        .row        (row),
        .frame_end  (frame_end),
        .red_offset (red_offset_reg),
        .min_pixels (min_pixels_reg),
        .q_stat     (q_stat),
        .pix_stall  (pix_stall),
        .push       (q_push),
        .push_data  (push_data)
    );

    // frame totals queue
    rpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // division and result beat
    rpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .pop_data    (pop_data),
        .pop         (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .found       (found),
        .mean_col_q4 (mean_col_q4),
        .mean_row_q4 (mean_row_q4)
    );

    // checks
    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, q_stat.full, !q_push, "push into full queue")
    `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, q_pop, !q_stat.empty, "pop from empty queue")
    `ASSERT_IMPLIES(a_zero_when_missing, clk, rst_n, res_valid && !found,
        (mean_col_q4 == '0) && (mean_row_q4 == '0), "nonzero mean without found")
    `ASSERT_NEXT(a_result_after_pop, clk, rst_n, q_pop && !pop_data.found,
        res_valid && !found, "missing result for empty frame")

endmodule

// ----- sv/rpc_front.sv -----
// front part: red test per pixel and per-frame accumulation
module rpc_front #(
    parameter logic [20:0] COUNT_CAP = 21'd1048576
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    input  logic [rpc_pkg::CHAN_W-1:0]    red,
    input  logic [rpc_pkg::CHAN_W-1:0]    green,
    input  logic [rpc_pkg::CHAN_W-1:0]    blue,
    input  logic [rpc_pkg::COORD_W-1:0]   col,
    input  logic [rpc_pkg::COORD_W-1:0]   row,
    input  logic                          frame_end,
    input  logic [rpc_pkg::CHAN_W-1:0]    red_offset,
    input  logic [rpc_pkg::COUNT_W-1:0]   min_pixels,
    input  rpc_pkg::q_status_t            q_stat,
    output logic                          pix_stall,
    output logic                          push,
    output rpc_pkg::frame_sum_t           push_data
);
    import rpc_pkg::*;

    logic [SUM_W-1:0]   col_sum_reg, col_sum_next;
    logic [SUM_W-1:0]   row_sum_reg, row_sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [10:0]        red_x2, blue_x3, green_x3, off_x2;
    logic               is_red;
    logic               accept;

    // hold the stream only while no frame slot is free
    assign pix_stall = q_stat.full;
    assign accept    = pix_valid && !pix_stall;

    // exact form of red > 1.5 * other + offset
    assign red_x2   = {2'b00, red, 1'b0};
    assign off_x2   = {2'b00, red_offset, 1'b0};
    assign blue_x3  = {3'b000, blue} + {2'b00, blue, 1'b0};
    assign green_x3 = {3'b000, green} + {2'b00, green, 1'b0};
    assign is_red   = (red_x2 > (blue_x3 + off_x2)) && (red_x2 > (green_x3 + off_x2))
                      && (count_reg < COUNT_CAP);

    // running totals including the current beat
    always_comb
    begin
        col_sum_next = col_sum_reg;
        row_sum_next = row_sum_reg;
        count_next   = count_reg;
        if (is_red)
        begin
            col_sum_next = col_sum_reg + {{(SUM_W-COORD_W){1'b0}}, col};
            row_sum_next = row_sum_reg + {{(SUM_W-COORD_W){1'b0}}, row};
            count_next   = count_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
        end
    end

    // frame totals go to the queue on the last beat
    assign push              = accept && frame_end;
    assign push_data.found   = count_next > min_pixels;
    assign push_data.col_sum = col_sum_next;
    assign push_data.row_sum = row_sum_next;
    assign push_data.count   = count_next;

    // accumulators, cleared after each frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_sum_reg <= '0;
            row_sum_reg <= '0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                col_sum_reg <= '0;
                row_sum_reg <= '0;
                count_reg   <= '0;
            end
            else
            begin
                col_sum_reg <= col_sum_next;
                row_sum_reg <= row_sum_next;
                count_reg   <= count_next;
            end
        end
    end

endmodule

// ----- sv/rpc_queue.sv -----
// short queue of frame totals between front and back
module rpc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rpc_pkg::frame_sum_t push_data,
    input  logic                pop,
    output rpc_pkg::frame_sum_t pop_data,
    output rpc_pkg::q_status_t  q_stat
);
    import rpc_pkg::*;

    frame_sum_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  fill_reg;

    assign q_stat.full  = fill_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_stat.empty = fill_reg == '0;
    assign pop_data     = slot_reg[rd_ptr_reg];

    // storage slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + {{(QPTR_W-1){1'b0}}, 1'b1};
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + {{(QPTR_W-1){1'b0}}, 1'b1};
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + {{(QCNT_W-1){1'b0}}, 1'b1};
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - {{(QCNT_W-1){1'b0}}, 1'b1};
            end
        end
    end

endmodule

// ----- sv/rpc_back.sv -----
// back part: serial division of both sums and the result register
module rpc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rpc_pkg::q_status_t           q_stat,
    input  rpc_pkg::frame_sum_t          pop_data,
    output logic                         pop,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic                         found,
    output logic [rpc_pkg::Q4_W-1:0]     mean_col_q4,
    output logic [rpc_pkg::Q4_W-1:0]     mean_row_q4
);
    import rpc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    // partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic [COUNT_W-1:0] rem;
        logic [Q4_W-1:0]    shift;
    } div_t;

    state_t             state_reg, state_next;
    div_t               col_div_reg, col_div_next, col_div_step;
    div_t               row_div_reg, row_div_next, row_div_step;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [3:0]         step_reg, step_next;
    logic               valid_reg, valid_next;
    logic               found_reg, found_next;
    logic [Q4_W-1:0]    mean_col_reg, mean_col_next;
    logic [Q4_W-1:0]    mean_row_reg, mean_row_next;

    // one restoring step: one quotient bit
    function automatic div_t div_step(div_t cur, logic [COUNT_W-1:0] divisor);
        logic [COUNT_W:0] trial;
        logic [COUNT_W:0] diff;
        logic             qbit;
        div_t             nxt;
        trial = {cur.rem, cur.shift[Q4_W-1]};
        diff  = trial - {1'b0, divisor};
        qbit  = trial >= {1'b0, divisor};
        nxt.rem   = qbit ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        nxt.shift = {cur.shift[Q4_W-2:0], qbit};
        return nxt;
    endfunction

    assign col_div_step = div_step(col_div_reg, count_reg);
    assign row_div_step = div_step(row_div_reg, count_reg);

    assign res_valid   = valid_reg;
    assign found       = found_reg;
    assign mean_col_q4 = mean_col_reg;
    assign mean_row_q4 = mean_row_reg;

    // sequencer: take a frame, divide if found, hold the result beat
    always_comb
    begin
        state_next    = state_reg;
        col_div_next  = col_div_reg;
        row_div_next  = row_div_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        valid_next    = valid_reg;
        found_next    = found_reg;
        mean_col_next = mean_col_reg;
        mean_row_next = mean_row_reg;
        pop           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    count_next = pop_data.count;
                    if (pop_data.found)
                    begin
                        // high sum bits are already below the count
                        col_div_next.rem   = {1'b0, pop_data.col_sum[SUM_W-1:COORD_W]};
                        col_div_next.shift = {pop_data.col_sum[COORD_W-1:0], {FRAC_W{1'b0}}};
                        row_div_next.rem   = {1'b0, pop_data.row_sum[SUM_W-1:COORD_W]};
                        row_div_next.shift = {pop_data.row_sum[COORD_W-1:0], {FRAC_W{1'b0}}};
                        step_next          = '0;
                        state_next         = ST_DIV;
                    end
                    else
                    begin
                        found_next    = 1'b0;
                        mean_col_next = '0;
                        mean_row_next = '0;
                        valid_next    = 1'b1;
                        state_next    = ST_HOLD;
                    end
                end
            end
            ST_DIV:
            begin
                col_div_next = col_div_step;
                row_div_next = row_div_step;
                step_next    = step_reg + 4'd1;
                if (step_reg == 4'(Q4_W - 1))
                begin
                    found_next    = 1'b1;
                    mean_col_next = col_div_step.shift;
                    mean_row_next = row_div_step.shift;
                    valid_next    = 1'b1;
                    state_next    = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!res_stall)
                begin
                    valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, divider and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            col_div_reg  <= '0;
            row_div_reg  <= '0;
            count_reg    <= '0;
            step_reg     <= '0;
            valid_reg    <= 1'b0;
            found_reg    <= 1'b0;
            mean_col_reg <= '0;
            mean_row_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            col_div_reg  <= col_div_next;
            row_div_reg  <= row_div_next;
            count_reg    <= count_next;
            step_reg     <= step_next;
            valid_reg    <= valid_next;
            found_reg    <= found_next;
            mean_col_reg <= mean_col_next;
            mean_row_reg <= mean_row_next;
        end
    end

endmodule
